// ----- rtl/jtl_pkg.sv -----
// Shared constants, register map and types of the joint trajectory limiter.
`timescale 1ns / 1ps

package jtl_pkg;

   localparam int VALUE_WIDTH_DEF  = 32;
   localparam int DATA_W           = 32;
   localparam int KP_W             = 24;
   localparam int STEP_W           = 31;
   localparam int PERIOD_W         = 24;
   localparam int MODE_W           = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;

   localparam int MUL_DIG_W        = 24;
   localparam int MUL_K_W          = 24;
   localparam int GAIN_FRAC_BITS   = 16;
   localparam int PERIOD_FRAC_BITS = 24;

   localparam int TWO_PI_Q16       = 411775;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

   localparam int MODE_WRAP_BIT    = 0;
   localparam int MODE_ONLINE_BIT  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP_GAIN          = 3'd0,
      CSR_ACCEL_STEP       = 3'd1,
      CSR_MAX_VELOCITY     = 3'd2,
      CSR_UPPER_LIMIT      = 3'd3,
      CSR_LOWER_LIMIT      = 3'd4,
      CSR_TICK_PERIOD      = 3'd5,
      CSR_INITIAL_POSITION = 3'd6,
      CSR_JOINT_MODE       = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [KP_W-1:0]          kp_gain;
      logic [STEP_W-1:0]        accel_step;
      logic [STEP_W-1:0]        max_velocity;
      logic signed [DATA_W-1:0] upper_limit;
      logic signed [DATA_W-1:0] lower_limit;
      logic [PERIOD_W-1:0]      tick_period;
      logic signed [DATA_W-1:0] initial_position;
      logic [MODE_W-1:0]        joint_mode;
      logic                     init_load;
   } cfg_type;

endpackage

// ----- rtl/jtl_if.sv -----
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps

interface jtl_req_if import jtl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] desired_position;
   logic signed [DATA_W-1:0] current_position;

   modport source (output valid, output desired_position, output current_position,
                   input ready);
   modport sink   (input valid, input desired_position, input current_position,
                   output ready);
endinterface

interface jtl_rsp_if import jtl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] position_command;
   logic signed [DATA_W-1:0] velocity_command;

   modport source (output valid, output position_command, output velocity_command,
                   input ready);
   modport sink   (input valid, input position_command, input velocity_command,
                   output ready);
endinterface

// ----- rtl/jtl_csr.sv -----
// Configuration register file with the initial position load strobe.
`timescale 1ns / 1ps

module jtl_csr import jtl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in           = cfg_ff;
      cfg_in.init_load = 1'b0;
      if (reset) begin
         cfg_in             = '0;
         cfg_in.tick_period = PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_KP_GAIN:          cfg_in.kp_gain          = csr_wdata[KP_W-1:0];
            CSR_ACCEL_STEP:       cfg_in.accel_step       = csr_wdata[STEP_W-1:0];
            CSR_MAX_VELOCITY:     cfg_in.max_velocity     = csr_wdata[STEP_W-1:0];
            CSR_UPPER_LIMIT:      cfg_in.upper_limit      = $signed(csr_wdata[DATA_W-1:0]);
            CSR_LOWER_LIMIT:      cfg_in.lower_limit      = $signed(csr_wdata[DATA_W-1:0]);
            CSR_TICK_PERIOD:      cfg_in.tick_period      = csr_wdata[PERIOD_W-1:0];
            CSR_INITIAL_POSITION: begin
               cfg_in.initial_position = $signed(csr_wdata[DATA_W-1:0]);
               cfg_in.init_load        = 1'b1;
            end
            CSR_JOINT_MODE:       cfg_in.joint_mode       = csr_wdata[MODE_W-1:0];
            default:              cfg_in.init_load        = 1'b0;
         endcase
      end
   end

   // synchronous reset is folded into the next-state logic
   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/jtl_mul.sv -----
// Shared iterative multiplier: one 24-bit digit of the magnitude per cycle, MSB first.
`timescale 1ns / 1ps

module jtl_mul import jtl_pkg::*; #(
   parameter int MAG_W = VALUE_WIDTH_DEF + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [MAG_W-1:0]      mag,
   input  logic [MUL_K_W-1:0]    k,
   output logic                  done,
   output logic [((MAG_W + MUL_DIG_W - 1) / MUL_DIG_W) * MUL_DIG_W + MUL_K_W - 1:0] prod
);

   localparam int NCH    = (MAG_W + MUL_DIG_W - 1) / MUL_DIG_W;
   localparam int PAD_W  = NCH * MUL_DIG_W;
   localparam int PROD_W = PAD_W + MUL_K_W;
   localparam int CNT_W  = $clog2(NCH + 1);

   logic [PAD_W-1:0]              mag_ff;
   logic [MUL_K_W-1:0]            k_ff;
   logic [PROD_W-1:0]             acc_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          done_ff;
   logic [MUL_DIG_W-1:0]          digit;
   logic [MUL_DIG_W+MUL_K_W-1:0]  partial;
   logic [PROD_W-1:0]             acc_in;

   assign digit   = mag_ff[PAD_W-1 -: MUL_DIG_W];
   assign partial = digit * k_ff;
   assign acc_in  = (acc_ff << MUL_DIG_W) + PROD_W'(partial);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CNT_W'(1));
         if (start) begin
            cnt_ff <= CNT_W'(NCH);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= PAD_W'(mag);
         k_ff   <= k;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         mag_ff <= mag_ff << MUL_DIG_W;
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ----- rtl/joint_trajectory_limiter_core.sv -----
// Top level: sequencer and datapath of the velocity and acceleration limited setpoint generator.
//
//   channel | direction | handshake       | payload
//   --------+-----------+-----------------+------------------------------------------
//   req     | in        | valid / ready   | desired_position, current_position
//   rsp     | out       | valid / ready   | position_command, velocity_command
//   csr     | in        | csr_we          | csr_index, csr_wdata (write only)
//
// From accept to the next accept, an item makes two passes through the shared 24x24 multiplier,
// first with kp_gain and then with tick_period.
// req.ready is high only while the sequencer is idle.
// A finished result sits in the output register; the next item is accepted while it waits.
// Synchronous reset clears velocity and position state; tick_period resets to 16777.
`timescale 1ns / 1ps

module joint_trajectory_limiter_core import jtl_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   jtl_req_if.sink                req,
   jtl_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int W      = VALUE_WIDTH;
   localparam int XW     = ((W > DATA_W) ? W : DATA_W) + 2;
   localparam int MAG_W  = W + 1;
   localparam int NCH    = (MAG_W + MUL_DIG_W - 1) / MUL_DIG_W;
   localparam int PROD_W = NCH * MUL_DIG_W + MUL_K_W;

   localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] VMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
   localparam logic [PROD_W-1:0]    LIM_POS = {{(PROD_W-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [PROD_W-1:0]    LIM_NEG = LIM_POS + PROD_W'(1);
   localparam logic signed [XW-1:0] TWO_PI_X = XW'(TWO_PI_Q16);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_ERR   = 9'b000000010,
      S_TGT   = 9'b000000100,
      S_CLMP  = 9'b000001000,
      S_VEL   = 9'b000010000,
      S_PMUL  = 9'b000100000,
      S_INTEG = 9'b001000000,
      S_WRAP  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
      logic signed [W-1:0] r;
      r = x[W-1:0];
      if (x > VMAX_X) r = VMAX_X[W-1:0];
      else if (x < VMIN_X) r = VMIN_X[W-1:0];
      return r;
   endfunction

   function automatic logic signed [XW-1:0] sxw(input logic signed [W-1:0] v);
      return XW'(v);
   endfunction

   // magnitude of a shifted product, capped to the range, sign restored
   function automatic logic signed [W-1:0] scale_out(input logic [PROD_W-1:0] p,
                                                     input logic neg);
      logic [PROD_W-1:0] cap;
      logic [W-1:0]      m;
      cap = p;
      if (neg && (p > LIM_NEG)) cap = LIM_NEG;
      else if (!neg && (p > LIM_POS)) cap = LIM_POS;
      m = cap[W-1:0];
      return neg ? $signed(W'(0) - m) : $signed(m);
   endfunction

   cfg_type              cfg;
   state_type            state_ff, state_in;

   logic signed [W-1:0]  vel_state_ff, vel_state_in;
   logic signed [W-1:0]  pos_state_ff, pos_state_in;
   logic signed [W-1:0]  des_ff, cur_ff, target_ff, work_ff;
   logic                 neg_ff;
   logic                 rsp_valid_ff;
   logic signed [DATA_W-1:0] pos_out_ff, vel_out_ff;

   logic                 mul_start, mul_done;
   logic [MAG_W-1:0]     mul_mag;
   logic [MUL_K_W-1:0]   mul_k;
   logic [PROD_W-1:0]    mul_prod, prod_sh;
   logic signed [W-1:0]  scaled;

   logic signed [W-1:0]  des_sat, cur_sat, maxv_w, step_w, upper_w, lower_w, init_w;
   logic                 err_neg;
   logic signed [XW-1:0] diff_ab, diff_ba, vel_x, vel_neg_x;
   logic [MAG_W-1:0]     err_mag, vel_mag;
   logic signed [W-1:0]  neg_maxv, target_clamped;
   logic signed [W-1:0]  s_up, s_dn, slew_cmd;
   logic signed [W-1:0]  base, integ_sum;
   logic                 wrap_mode;
   logic signed [W-1:0]  step_a, step_b;
   logic signed [XW-1:0] step_b_x, vel_out_x;
   logic                 out_load;

   jtl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jtl_mul #(.MAG_W(MAG_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mag   (mul_mag),
      .k     (mul_k),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // register values held to the working range
   assign des_sat = sat(XW'(req.desired_position));
   assign cur_sat = sat(XW'(req.current_position));
   assign maxv_w  = sat(XW'(cfg.max_velocity));
   assign step_w  = sat(XW'(cfg.accel_step));
   assign upper_w = sat(XW'(cfg.upper_limit));
   assign lower_w = sat(XW'(cfg.lower_limit));
   assign init_w  = sat(XW'(cfg.initial_position));

   // position error magnitude without a separate negate
   assign err_neg = des_ff < cur_ff;
   assign diff_ab = sxw(des_ff) - sxw(cur_ff);
   assign diff_ba = sxw(cur_ff) - sxw(des_ff);
   assign err_mag = err_neg ? diff_ba[MAG_W-1:0] : diff_ab[MAG_W-1:0];

   assign vel_x     = sxw(vel_state_ff);
   assign vel_neg_x = XW'(0) - vel_x;
   assign vel_mag   = vel_state_ff[W-1] ? vel_neg_x[MAG_W-1:0] : vel_x[MAG_W-1:0];

   assign mul_start = (state_ff == S_ERR) || (state_ff == S_PMUL);
   assign mul_mag   = (state_ff == S_ERR) ? err_mag : vel_mag;
   assign mul_k     = (state_ff == S_ERR) ? cfg.kp_gain : cfg.tick_period;

   assign prod_sh = (state_ff == S_INTEG) ? (mul_prod >> PERIOD_FRAC_BITS)
                                          : (mul_prod >> GAIN_FRAC_BITS);
   assign scaled  = scale_out(prod_sh, neg_ff);

   // symmetric velocity clamp
   assign neg_maxv = -maxv_w;
   always_comb begin
      target_clamped = target_ff;
      if (target_ff > maxv_w) target_clamped = maxv_w;
      else if (target_ff < neg_maxv) target_clamped = neg_maxv;
   end

   // slew toward the target, never past it
   assign s_up = sat(vel_x + sxw(step_w));
   assign s_dn = sat(vel_x - sxw(step_w));
   always_comb begin
      if (target_ff > vel_state_ff) begin
         slew_cmd = (s_up > target_ff) ? target_ff : s_up;
      end else begin
         slew_cmd = (s_dn < target_ff) ? target_ff : s_dn;
      end
   end

   assign base      = cfg.joint_mode[MODE_ONLINE_BIT] ? cur_ff : pos_state_ff;
   assign integ_sum = sat(sxw(base) + sxw(scaled));

   // continuous joint: low wrap then high wrap; otherwise upper clamp then lower clamp
   assign wrap_mode = cfg.joint_mode[MODE_WRAP_BIT];
   always_comb begin
      if (wrap_mode) begin
         step_a = (pos_state_ff < lower_w) ? sat(sxw(pos_state_ff) + TWO_PI_X) : pos_state_ff;
         step_b = (work_ff > upper_w) ? sat(sxw(work_ff) - TWO_PI_X) : work_ff;
      end else begin
         step_a = (pos_state_ff > upper_w) ? upper_w : pos_state_ff;
         step_b = (work_ff < lower_w) ? lower_w : work_ff;
      end
   end

   assign step_b_x  = sxw(step_b);
   assign vel_out_x = sxw(vel_state_ff);
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req.valid) state_in = S_ERR;
         S_ERR:   state_in = S_TGT;
         S_TGT:   if (mul_done) state_in = S_CLMP;
         S_CLMP:  state_in = S_VEL;
         S_VEL:   state_in = S_PMUL;
         S_PMUL:  state_in = S_INTEG;
         S_INTEG: if (mul_done) state_in = S_WRAP;
         S_WRAP:  state_in = S_DONE;
         S_DONE:  if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vel_state_in = vel_state_ff;
      pos_state_in = pos_state_ff;
      if (cfg.init_load) begin
         vel_state_in = '0;
         pos_state_in = init_w;
      end else begin
         if (state_ff == S_VEL) vel_state_in = slew_cmd;
         if ((state_ff == S_INTEG) && mul_done) pos_state_in = integ_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vel_state_ff <= '0;
         pos_state_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vel_state_ff <= vel_state_in;
         pos_state_ff <= pos_state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req.valid) begin
         des_ff <= des_sat;
         cur_ff <= cur_sat;
      end
      if (state_ff == S_ERR) neg_ff <= err_neg;
      if (state_ff == S_PMUL) neg_ff <= vel_state_ff[W-1];
      if ((state_ff == S_TGT) && mul_done) target_ff <= scaled;
      if (state_ff == S_CLMP) target_ff <= target_clamped;
      if (state_ff == S_WRAP) work_ff <= step_a;
      if (out_load) begin
         pos_out_ff <= step_b_x[DATA_W-1:0];
         vel_out_ff <= vel_out_x[DATA_W-1:0];
      end
   end

   assign req.ready            = (state_ff == S_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.position_command = pos_out_ff;
   assign rsp.velocity_command = vel_out_ff;

`ifndef SYNTHESIS
   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while an item is in flight");

   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ((state_ff == S_TGT) || (state_ff == S_INTEG)))
      else $error("multiplier finished outside a wait state");

   a_init_zeroes_velocity: assert property (@(posedge clock) disable iff (reset)
      (cfg.init_load && (state_ff == S_IDLE)) |=> (vel_state_ff == '0))
      else $error("initial position load did not clear velocity");
`endif

endmodule

// ----- test/jtl_setpoint_checker.sv -----
// Watches the joint limiter channels, predicts each setpoint and compares the results.
`timescale 1ns / 1ps

module jtl_setpoint_checker import jtl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   jtl_req_if                     req,
   jtl_rsp_if                     rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     in_flight
);

   localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint WORD_MIN = -(longint'(1) <<< (DATA_W - 1));

   typedef struct packed {
      logic signed [DATA_W-1:0] position_command;
      logic signed [DATA_W-1:0] velocity_command;
   } setpoint_type;

   // register mirror and joint state
   logic [KP_W-1:0]          kp_gain;
   logic [STEP_W-1:0]        accel_step;
   logic [STEP_W-1:0]        max_velocity;
   logic signed [DATA_W-1:0] upper_limit;
   logic signed [DATA_W-1:0] lower_limit;
   logic [PERIOD_W-1:0]      tick_period;
   logic [MODE_W-1:0]        joint_mode;
   longint                   velocity_now;
   longint                   position_now;

   setpoint_type pending_setpoints[$];
   int           result_index;

   function automatic longint clamp_word(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
   endfunction

   // (x * k) >> sh on the magnitude, truncated toward zero, then saturated
   function automatic longint scale_trunc(longint x, longint unsigned k, int sh);
      longint unsigned mag;
      longint unsigned lo_mask;
      longint unsigned p;
      longint          r;
      mag = (x < 0) ? -x : x;
      lo_mask = (64'd1 << sh) - 64'd1;
      p = (mag >> sh) * k + (((mag & lo_mask) * k) >> sh);
      if (p > 64'h8000_0000) p = 64'h8000_0000;
      r = p;
      return clamp_word((x < 0) ? -r : r);
   endfunction

   function automatic setpoint_type advance_joint(logic signed [DATA_W-1:0] desired,
                                                  logic signed [DATA_W-1:0] measured);
      longint       target;
      longint       cmd;
      longint       base;
      longint       pos;
      longint       vlimit;
      longint       step;
      setpoint_type sp;
      vlimit = longint'(max_velocity);
      step   = longint'(accel_step);
      target = scale_trunc(longint'(desired) - longint'(measured), 64'(kp_gain),
                           GAIN_FRAC_BITS);
      if (target > vlimit) target = vlimit;
      if (target < -vlimit) target = -vlimit;

      // slew toward the target, never past it
      if (target > velocity_now) begin
         cmd = clamp_word(velocity_now + step);
         if (cmd > target) cmd = target;
      end else begin
         cmd = clamp_word(velocity_now - step);
         if (cmd < target) cmd = target;
      end
      velocity_now = cmd;

      base = joint_mode[MODE_ONLINE_BIT] ? longint'(measured) : position_now;
      position_now = clamp_word(base + scale_trunc(velocity_now, 64'(tick_period),
                                                   PERIOD_FRAC_BITS));

      // stored position stays unclamped; only the reported one is limited
      pos = position_now;
      if (joint_mode[MODE_WRAP_BIT]) begin
         if (pos < longint'(lower_limit)) pos = clamp_word(pos + TWO_PI_Q16);
         if (pos > longint'(upper_limit)) pos = clamp_word(pos - TWO_PI_Q16);
      end else begin
         if (pos > longint'(upper_limit)) pos = longint'(upper_limit);
         if (pos < longint'(lower_limit)) pos = longint'(lower_limit);
      end
      sp.position_command = pos[DATA_W-1:0];
      sp.velocity_command = velocity_now[DATA_W-1:0];
      return sp;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("tb: mismatch on result %0d, %s: got %h, want %h at %0t",
               result_index, what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      setpoint_type got;
      setpoint_type want;
      if (reset) begin
         kp_gain      = '0;
         accel_step   = '0;
         max_velocity = '0;
         upper_limit  = '0;
         lower_limit  = '0;
         tick_period  = PERIOD_RESET;
         joint_mode   = '0;
         velocity_now = 0;
         position_now = 0;
         pending_setpoints.delete();
         result_index = 0;
         error_count  = 0;
         in_flight   <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_KP_GAIN:      kp_gain      = csr_wdata[KP_W-1:0];
               CSR_ACCEL_STEP:   accel_step   = csr_wdata[STEP_W-1:0];
               CSR_MAX_VELOCITY: max_velocity = csr_wdata[STEP_W-1:0];
               CSR_UPPER_LIMIT:  upper_limit  = csr_wdata;
               CSR_LOWER_LIMIT:  lower_limit  = csr_wdata;
               CSR_TICK_PERIOD:  tick_period  = csr_wdata[PERIOD_W-1:0];
               CSR_INITIAL_POSITION: begin
                  position_now = longint'(signed'(csr_wdata));
                  velocity_now = 0;
               end
               CSR_JOINT_MODE:   joint_mode   = csr_wdata[MODE_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            pending_setpoints.push_back(advance_joint(req.desired_position,
                                                      req.current_position));
         if (rsp.valid && rsp.ready) begin
            got.position_command = rsp.position_command;
            got.velocity_command = rsp.velocity_command;
            if (pending_setpoints.size() == 0) begin
               report_mismatch("item with none pending", got.position_command, '0);
            end else begin
               want = pending_setpoints.pop_front();
               if (got.position_command !== want.position_command)
                  report_mismatch("position_command", got.position_command,
                                  want.position_command);
               if (got.velocity_command !== want.velocity_command)
                  report_mismatch("velocity_command", got.velocity_command,
                                  want.velocity_command);
            end
            result_index++;
         end
         in_flight <= pending_setpoints.size();
      end
   end

endmodule

// ----- test/tb_joint_trajectory_limiter_core.sv -----
// Stimulus and verdict for the joint trajectory limiter core.
`timescale 1ns / 1ps

module tb_joint_trajectory_limiter_core;
   import jtl_pkg::*;

   localparam int CLOCK_LIMIT   = 300000;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int PI_Q16        = 205887;

   localparam logic [MODE_W-1:0] MODE_CLAMP       = 2'b00;
   localparam logic [MODE_W-1:0] MODE_WRAP        = 2'b01;
   localparam logic [MODE_W-1:0] MODE_ONLINE      = 2'b10;
   localparam logic [MODE_W-1:0] MODE_WRAP_ONLINE = 2'b11;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   sink_ready = 1'b0;
   logic                   gaps_on = 1'b1;
   logic                   hold_toggle = 1'b0;
   logic                   hold_seen = 1'b0;
   int                     hold_left = 0;
   int                     cycle_count = 0;
   int                     error_count;
   int                     in_flight;

   jtl_req_if req_if ();
   jtl_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   joint_trajectory_limiter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   jtl_setpoint_checker setpoint_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .in_flight   (in_flight)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever the toggle flips
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HOLD_CYCLES;
         sink_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= !(gaps_on && $urandom_range(99) < 21);
      end
   end

   function automatic cfg_type make_setting(logic [KP_W-1:0] kp, logic [STEP_W-1:0] accel,
                                            logic [STEP_W-1:0] vmax,
                                            logic signed [DATA_W-1:0] upper,
                                            logic signed [DATA_W-1:0] lower,
                                            logic [PERIOD_W-1:0] period,
                                            logic signed [DATA_W-1:0] start,
                                            logic [MODE_W-1:0] mode, logic load);
      cfg_type s;
      s.kp_gain          = kp;
      s.accel_step       = accel;
      s.max_velocity     = vmax;
      s.upper_limit      = upper;
      s.lower_limit      = lower;
      s.tick_period      = period;
      s.initial_position = start;
      s.joint_mode       = mode;
      s.init_load        = load;
      return s;
   endfunction

   function automatic logic [31:0] pick_value(logic [31:0] full, logic [31:0] usual);
      int unsigned r;
      r = $urandom_range(9);
      if (r == 0) return '0;
      if (r == 1) return full;
      if (r == 2) return $urandom & full;
      return $urandom_range(usual);
   endfunction

   function automatic logic [DATA_W-1:0] extreme_word();
      case ($urandom_range(3))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   function automatic cfg_type random_setting();
      cfg_type s;
      s.kp_gain      = KP_W'(pick_value(32'h00FF_FFFF, 32'h000A_0000));
      s.accel_step   = STEP_W'(pick_value(32'h7FFF_FFFF, 32'h0004_0000));
      s.max_velocity = STEP_W'(pick_value(32'h7FFF_FFFF, 32'h0020_0000));
      case ($urandom_range(5))
         0: begin
            s.upper_limit = 32'h7FFF_FFFF;
            s.lower_limit = 32'h8000_0000;
         end
         1: begin
            s.upper_limit = $urandom;
            s.lower_limit = $urandom;
         end
         2: begin
            s.upper_limit = PI_Q16;
            s.lower_limit = -PI_Q16;
         end
         default: begin
            s.upper_limit = $urandom_range(32'h0006_0000);
            s.lower_limit = -$signed($urandom_range(32'h0006_0000));
         end
      endcase
      case ($urandom_range(4))
         0:       s.tick_period = '0;
         1:       s.tick_period = '1;
         2:       s.tick_period = PERIOD_W'($urandom);
         3:       s.tick_period = PERIOD_RESET;
         default: s.tick_period = PERIOD_W'($urandom_range(32'h0004_0000, 1));
      endcase
      if ($urandom_range(3) == 0) s.initial_position = $urandom;
      else s.initial_position = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      s.joint_mode = MODE_W'($urandom_range(3));
      s.init_load  = 1'($urandom_range(1));
      return s;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // unused upper bits of the narrow registers carry noise
   task automatic apply_setting(input cfg_type s);
      write_reg(CSR_KP_GAIN, {8'($urandom), s.kp_gain});
      write_reg(CSR_ACCEL_STEP, {1'($urandom), s.accel_step});
      write_reg(CSR_MAX_VELOCITY, {1'($urandom), s.max_velocity});
      write_reg(CSR_UPPER_LIMIT, s.upper_limit);
      write_reg(CSR_LOWER_LIMIT, s.lower_limit);
      write_reg(CSR_TICK_PERIOD, {8'($urandom), s.tick_period});
      write_reg(CSR_JOINT_MODE, {30'($urandom), s.joint_mode});
      if (s.init_load) write_reg(CSR_INITIAL_POSITION, s.initial_position);
      csr_we <= 1'b0;
   endtask

   // valid stays high after an accept unless the next item opens with a gap
   task automatic send_item(input logic [DATA_W-1:0] desired, input logic [DATA_W-1:0] measured);
      if (gaps_on && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 21);
      end
      req_if.valid            <= 1'b1;
      req_if.desired_position <= desired;
      req_if.current_position <= measured;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_until_settled();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic signed [DATA_W-1:0] track;
      logic signed [DATA_W-1:0] offset;
      int                       random_count;
      int                       phase;
      int                       phase_len;
      int unsigned              r;

      track        = '0;
      random_count = 0;
      phase        = 0;
      req_if.valid            <= 1'b0;
      req_if.desired_position <= '0;
      req_if.current_position <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: zero gain keeps everything at rest
      send_item(32'h0001_0000, 32'h0);
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      wait_until_settled();

      // full range: saturating error, gain product and integration
      apply_setting(make_setting(24'h01_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h8000_0000, 24'hFF_FFFF, 32'h0, MODE_CLAMP, 1'b1));
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h0, 32'h0);
      wait_until_settled();

      // zero limits hold the velocity; crossed limits let the lower one win
      apply_setting(make_setting(24'hFF_FFFF, 31'h0, 31'h0, 32'h0001_0000, 32'h0002_0000,
                                 24'h0, 32'h0001_8000, MODE_CLAMP, 1'b1));
      send_item(32'h0005_0000, 32'h0003_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      wait_until_settled();

      // continuous joint passing the upper limit and wrapping back
      apply_setting(make_setting(24'h02_0000, 31'h1_0000, 31'h3_0000, PI_Q16, -PI_Q16,
                                 24'hFF_FFFF, 32'sd200000, MODE_WRAP, 1'b1));
      send_item(32'h7FFF_0000, 32'h0);
      send_item(32'h7FFF_0000, 32'h0);
      send_item(32'h8000_0000, 32'h0);
      wait_until_settled();

      // measured base with wraps that saturate at the top of the range
      apply_setting(make_setting(24'h01_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h0, MODE_WRAP_ONLINE, 1'b0));
      send_item(32'h7FFF_0000, 32'h7FFF_0000);
      send_item(32'h8001_0000, 32'h8000_0000);
      wait_until_settled();

      // measured base below the lower limit wraps up
      apply_setting(make_setting(24'h01_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, PI_Q16, -PI_Q16,
                                 24'hFF_FFFF, 32'h0, MODE_WRAP_ONLINE, 1'b0));
      send_item(-32'sd300000, -32'sd300000);
      send_item(32'h8000_0000, 32'h8000_0000);
      wait_until_settled();

      // online mode with a small acceleration step
      apply_setting(make_setting(24'h05_0000, 31'h800, 31'h2_0000, 32'h0004_0000,
                                 -32'sh0004_0000, 24'd16777, 32'h0, MODE_ONLINE, 1'b1));
      send_item(32'h0001_0000, 32'h0);
      send_item(32'h0001_0000, 32'h0000_0100);
      send_item(32'hFFFF_0000, 32'h0);
      wait_until_settled();

      while (random_count < RANDOM_ITEMS) begin
         apply_setting(random_setting());
         gaps_on <= (phase != 2);
         // fill the block against a stalled result side
         if (phase == 1) hold_toggle <= ~hold_toggle;
         phase_len = (phase == 2) ? 200 : $urandom_range(100, 20);
         repeat (phase_len) begin
            r = $urandom_range(19);
            if (r == 0) begin
               send_item($urandom, $urandom);
            end else if (r == 1) begin
               send_item(extreme_word(), extreme_word());
            end else begin
               // trajectory: target drifts, the measurement trails near it
               track  = track + $signed($urandom_range(32'h4000)) - 32'sh2000;
               offset = $signed($urandom_range(32'h0001_0000)) - 32'sh8000;
               send_item(track, track + offset);
            end
            random_count++;
         end
         wait_until_settled();
         phase++;
      end

      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
